### design/rrid_pkg.sv
// Shared types and constants of the run-length RGBA image decoder.
`default_nettype none

package rrid_pkg;

   localparam int DIM_BITS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // command kinds passed from the parser to the run placement unit
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] CMD_RUN   = 2'd0;
   localparam logic [KIND_W-1:0] CMD_IMAGE = 2'd1;
   localparam logic [KIND_W-1:0] CMD_ERROR = 2'd2;

   typedef struct packed {
      logic [7:0] len;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } run_type;

   localparam int RUN_W = $bits(run_type);

   typedef struct packed {
      logic [15:0] start_col;
      logic [15:0] start_row;
      logic [7:0]  run_length;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        image_done;
      logic        header_error;
   } result_type;

endpackage

`default_nettype wire

### design/rrid_queue.sv
// Small command queue between the byte parser and the run placement unit.
`default_nettype none

module rrid_queue import rrid_pkg::*; #(
   parameter int DEPTH  = QUEUE_DEPTH_DEF,
   parameter int DATA_W = RUN_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [KIND_W-1:0] push_kind,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output logic [KIND_W-1:0]      pop_kind,
   output logic [DATA_W-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [KIND_W+DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign {pop_kind, pop_data} = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= {push_kind, push_data};
      end
   end

endmodule

`default_nettype wire

### design/rrid_front.sv
// Byte parser: header fields and run records, turned into queue commands.
`default_nettype none

module rrid_front import rrid_pkg::*; #(
   parameter int DIM_BITS = DIM_BITS_DEF,
   parameter int DATA_W   = RUN_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_image_start,
   output logic                   q_push,
   output logic [KIND_W-1:0]      q_kind,
   output logic [DATA_W-1:0]      q_data,
   input  wire logic              q_full
);

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_WIDTH  = 4'd1;
   localparam logic [3:0] PH_HEIGHT = 4'd2;
   localparam logic [3:0] PH_FLAG   = 4'd3;
   localparam logic [3:0] PH_LEN    = 4'd4;
   localparam logic [3:0] PH_ALPHA  = 4'd5;
   localparam logic [3:0] PH_RED    = 4'd6;
   localparam logic [3:0] PH_GREEN  = 4'd7;
   localparam logic [3:0] PH_BLUE   = 4'd8;
   localparam logic [3:0] PH_ERROR  = 4'd9;

   logic [3:0]  phase_ff, phase_in, phase_cur;
   logic [1:0]  count_ff, count_in, count_cur;
   logic [31:0] width_ff, width_in, width_cur;
   logic [31:0] height_ff, height_in, height_cur;
   logic        alpha_present_ff, alpha_present_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  alpha_ff, alpha_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;

   logic          accept;
   logic [31:0]   byte_shifted;
   logic [31:0]   dim_next;
   logic          dim_big;
   logic          last_byte;
   run_type       run_clear;
   run_type       run_full;
   logic [2*DIM_BITS-1:0] dims;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // a start byte restarts parsing and is itself width byte 0
   assign phase_cur  = req_image_start ? PH_WIDTH : phase_ff;
   assign count_cur  = req_image_start ? 2'd0 : count_ff;
   assign width_cur  = req_image_start ? 32'd0 : width_ff;
   assign height_cur = req_image_start ? 32'd0 : height_ff;

   assign byte_shifted = 32'(req_data_byte) << {count_cur, 3'b000};
   assign dim_next     = ((phase_cur == PH_HEIGHT) ? height_cur : width_cur) | byte_shifted;
   assign dim_big      = (dim_next >> DIM_BITS) != 32'd0;
   assign last_byte    = (count_cur == 2'd3);

   assign run_clear = '{len: len_ff, red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0};
   assign run_full  = '{len: len_ff, red: red_ff, green: green_ff, blue: req_data_byte,
                        alpha: alpha_present_ff ? alpha_ff : 8'hFF};
   assign dims      = {height_cur[DIM_BITS-1:0], width_cur[DIM_BITS-1:0]};

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      alpha_present_in = alpha_present_ff;
      len_in           = len_ff;
      alpha_in         = alpha_ff;
      red_in           = red_ff;
      green_in         = green_ff;
      q_push           = 1'b0;
      q_kind           = CMD_RUN;
      q_data           = DATA_W'(run_full);
      if (accept) begin
         phase_in         = phase_cur;
         count_in         = count_cur;
         width_in         = width_cur;
         height_in        = height_cur;
         alpha_present_in = req_image_start ? 1'b0 : alpha_present_ff;
         case (phase_cur)
            PH_WIDTH, PH_HEIGHT: begin
               if (phase_cur == PH_WIDTH) begin
                  width_in = dim_next;
               end else begin
                  height_in = dim_next;
               end
               count_in = count_cur + 1'b1;
               if (last_byte) begin
                  if (dim_big) begin
                     q_push   = 1'b1;
                     q_kind   = CMD_ERROR;
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = (phase_cur == PH_WIDTH) ? PH_HEIGHT : PH_FLAG;
                  end
               end
            end
            PH_FLAG: begin
               alpha_present_in = (req_data_byte != 8'd0);
               q_push   = 1'b1;
               q_kind   = CMD_IMAGE;
               q_data   = DATA_W'(dims);
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = req_data_byte;
               phase_in = alpha_present_ff ? PH_ALPHA : PH_RED;
            end
            PH_ALPHA: begin
               alpha_in = req_data_byte;
               if (req_data_byte == 8'd0) begin
                  q_push   = 1'b1;
                  q_kind   = CMD_RUN;
                  q_data   = DATA_W'(run_clear);
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_RED;
               end
            end
            PH_RED: begin
               red_in   = req_data_byte;
               phase_in = PH_GREEN;
            end
            PH_GREEN: begin
               green_in = req_data_byte;
               phase_in = PH_BLUE;
            end
            PH_BLUE: begin
               q_push   = 1'b1;
               q_kind   = CMD_RUN;
               q_data   = DATA_W'(run_full);
               phase_in = PH_LEN;
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         count_ff         <= 2'd0;
         width_ff         <= 32'd0;
         height_ff        <= 32'd0;
         alpha_present_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         count_ff         <= count_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         alpha_present_ff <= alpha_present_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      alpha_ff <= alpha_in;
      red_ff   <= red_in;
      green_ff <= green_in;
   end

endmodule

`default_nettype wire

### design/rrid_back.sv
// Run placement: clipping, row wrap by iterative division, result register.
`default_nettype none

module rrid_back import rrid_pkg::*; #(
   parameter int DIM_BITS = DIM_BITS_DEF,
   parameter int DATA_W   = RUN_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  wire logic [KIND_W-1:0] q_kind,
   input  wire logic [DATA_W-1:0] q_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output result_type             result
);

   localparam logic [2:0] BS_IDLE = 3'd0;
   localparam logic [2:0] BS_MUL  = 3'd1;
   localparam logic [2:0] BS_SIZE = 3'd2;
   localparam logic [2:0] BS_CLIP = 3'd3;
   localparam logic [2:0] BS_DIV  = 3'd4;
   localparam logic [2:0] BS_EMIT = 3'd5;

   localparam int POS_W = DIM_BITS + 1;
   localparam int DIV_W = DIM_BITS + 8;

   logic [2:0]            state_ff, state_in;
   run_type               run_ff, run_in;
   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [2*DIM_BITS-1:0] prod_ff, prod_in;
   logic [31:0]           left_ff, left_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [POS_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      divisor_ff, divisor_in;
   logic [7:0]            quot_ff, quot_in;
   logic [2:0]            step_ff, step_in;
   result_type            res_ff, res_in;
   result_type            out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;

   logic [63:0]      prod_wide;
   logic [7:0]       clip_len;
   logic [31:0]      left_after;
   logic [POS_W-1:0] pos;
   logic [DIV_W-1:0] rem_ext;
   logic [DIV_W-1:0] rem_sub;
   logic             quot_bit;
   logic [7:0]       quot_next;
   logic [POS_W-1:0] rem_next;
   logic             slot_free;

   assign q_pop     = (state_ff == BS_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign result    = out_ff;
   assign slot_free = !out_valid_ff || rsp_pop;

   assign prod_wide  = 64'(prod_ff);
   assign clip_len   = (32'(run_ff.len) > left_ff) ? left_ff[7:0] : run_ff.len;
   assign left_after = left_ff - 32'(clip_len);
   assign pos        = POS_W'(col_ff) + POS_W'(clip_len);
   assign rem_ext    = DIV_W'(rem_ff);
   assign rem_sub    = rem_ext - divisor_ff;
   assign quot_bit   = (rem_ext >= divisor_ff);
   assign quot_next  = {quot_ff[6:0], quot_bit};
   assign rem_next   = quot_bit ? rem_sub[POS_W-1:0] : rem_ff;

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      prod_in      = prod_ff;
      left_in      = left_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         BS_IDLE: begin
            if (!q_empty) begin
               case (q_kind)
                  CMD_RUN: begin
                     run_in   = run_type'(q_data[RUN_W-1:0]);
                     state_in = BS_CLIP;
                  end
                  CMD_IMAGE: begin
                     width_in  = q_data[DIM_BITS-1:0];
                     height_in = q_data[2*DIM_BITS-1:DIM_BITS];
                     state_in  = BS_MUL;
                  end
                  CMD_ERROR: begin
                     res_in              = '0;
                     res_in.header_error = 1'b1;
                     state_in            = BS_EMIT;
                  end
                  default: begin
                     state_in = BS_IDLE;
                  end
               endcase
            end
         end
         BS_MUL: begin
            prod_in  = width_ff * height_ff;
            state_in = BS_SIZE;
         end
         BS_SIZE: begin
            left_in  = (prod_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod_wide[31:0];
            col_in   = '0;
            row_in   = '0;
            state_in = BS_IDLE;
         end
         BS_CLIP: begin
            if (clip_len == 8'd0) begin
               state_in = BS_IDLE;
            end else begin
               left_in             = left_after;
               res_in.start_col    = 16'(col_ff);
               res_in.start_row    = 16'(row_ff);
               res_in.run_length   = clip_len;
               res_in.red          = run_ff.red;
               res_in.green        = run_ff.green;
               res_in.blue         = run_ff.blue;
               res_in.alpha        = run_ff.alpha;
               res_in.image_done   = (left_after == 32'd0);
               res_in.header_error = 1'b0;
               if (pos < POS_W'(width_ff)) begin
                  col_in   = pos[DIM_BITS-1:0];
                  state_in = BS_EMIT;
               end else begin
                  // quotient is below 256, so eight restoring steps suffice
                  rem_in     = pos;
                  divisor_in = DIV_W'(width_ff) << 7;
                  quot_in    = 8'd0;
                  step_in    = 3'd7;
                  state_in   = BS_DIV;
               end
            end
         end
         BS_DIV: begin
            rem_in     = rem_next;
            quot_in    = quot_next;
            divisor_in = divisor_ff >> 1;
            step_in    = step_ff - 1'b1;
            if (step_ff == 3'd0) begin
               col_in   = rem_next[DIM_BITS-1:0];
               row_in   = row_ff + DIM_BITS'(quot_next);
               state_in = BS_EMIT;
            end
         end
         BS_EMIT: begin
            if (slot_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         left_ff      <= 32'd0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff     <= run_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

### design/rle_rgba_image_decoder.sv
// Run-length RGBA image decoder, top level.
// Takes one byte of the compressed image per accepted item: a header (32-bit
// little-endian width and height, then a has-alpha byte) followed by run
// records, and gives one run descriptor (start column, start row, clipped
// length, RGBA) per record that covers at least one pixel. A dimension above
// 2^DIM_BITS-1 gives a single result with header_error set; a byte with
// image_start set restarts decoding at any point. The parser takes a byte
// every cycle while its command queue (QUEUE_DEPTH entries) has room. The
// placement unit behind it takes a run through clip and emit states, with
// a division state for the row wrap between them (one quotient bit per
// cycle) when it crosses a row edge; a header takes multiply and size
// states. Results wait in an output register; a stalled consumer holds
// back the placement unit first, the parser only once the queue has filled.
`default_nettype none

module rle_rgba_image_decoder import rrid_pkg::*; #(
   parameter int DIM_BITS    = DIM_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_image_start,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [15:0]      rsp_start_col,
   output logic [15:0]      rsp_start_row,
   output logic [7:0]       rsp_run_length,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_image_done,
   output logic             rsp_header_error
);

   localparam int DATA_W = (2 * DIM_BITS > RUN_W) ? 2 * DIM_BITS : RUN_W;

   logic              q_push;
   logic [KIND_W-1:0] q_push_kind;
   logic [DATA_W-1:0] q_push_data;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   logic [KIND_W-1:0] q_pop_kind;
   logic [DATA_W-1:0] q_pop_data;
   result_type        result;

   rrid_front #(
      .DIM_BITS (DIM_BITS),
      .DATA_W   (DATA_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_image_start (req_image_start),
      .q_push          (q_push),
      .q_kind          (q_push_kind),
      .q_data          (q_push_data),
      .q_full          (q_full)
   );

   rrid_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_kind (q_push_kind),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_kind  (q_pop_kind),
      .pop_data  (q_pop_data)
   );

   rrid_back #(
      .DIM_BITS (DIM_BITS),
      .DATA_W   (DATA_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_kind    (q_pop_kind),
      .q_data    (q_pop_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .result    (result)
   );

   assign rsp_start_col    = result.start_col;
   assign rsp_start_row    = result.start_row;
   assign rsp_run_length   = result.run_length;
   assign rsp_red          = result.red;
   assign rsp_green        = result.green;
   assign rsp_blue         = result.blue;
   assign rsp_alpha        = result.alpha;
   assign rsp_image_done   = result.image_done;
   assign rsp_header_error = result.header_error;

`ifndef SYNTH
   // an error item carries no run
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_header_error) |-> (rsp_run_length == 8'd0 && !rsp_image_done))
      else $error("error item carries run data");

   // a run item always covers at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_header_error) |-> (rsp_run_length != 8'd0))
      else $error("empty run item delivered");

   // the parser never issues a command the queue cannot take
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire

### bench/rle_rgba_image_decoder_tb.sv
// Self-checking testbench for the run-length RGBA image decoder.
`timescale 1ns / 100ps

module rle_rgba_image_decoder_tb import rrid_pkg::*;;

   localparam longint unsigned DIM_MAX = (64'd1 << DIM_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_BYTES = 900;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WIDTH, PH_HEIGHT, PH_FLAG, PH_LEN, PH_ALPHA,
      PH_RED, PH_GREEN, PH_BLUE, PH_ERROR, PH_DONE
   } parse_phase_type;

   // Tracks the decoder's parse state and holds the run descriptors still due.
   class run_checker;
      parse_phase_type phase;
      int unsigned  hdr_count;
      logic [31:0]  img_width, img_height, pix_left, col, row;
      logic         alpha_on;
      logic [7:0]   run_len, run_alpha, run_red, run_green;
      result_type   expected_runs[$];
      int           errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         phase = PH_IDLE;
         hdr_count = 0;
         img_width = '0;
         img_height = '0;
         pix_left = '0;
         col = '0;
         row = '0;
         alpha_on = 1'b0;
         run_len = '0;
         run_alpha = '0;
         run_red = '0;
         run_green = '0;
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction

      function void place_run(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
         logic [31:0] len;
         logic [63:0] pos;
         result_type  res;
         phase = PH_LEN;
         len = 32'(run_len);
         if (len > pix_left) len = pix_left;
         if (len == 0) return;
         res = '0;
         res.start_col = col[15:0];
         res.start_row = row[15:0];
         res.run_length = len[7:0];
         res.red = r;
         res.green = g;
         res.blue = b;
         res.alpha = a;
         pix_left = pix_left - len;
         // pixels were left, so the width cannot be zero here
         pos = 64'(col) + 64'(len);
         row = row + 32'(pos / 64'(img_width));
         col = 32'(pos % 64'(img_width));
         res.image_done = (pix_left == 0);
         if (pix_left == 0) phase = PH_DONE;
         expected_runs.push_back(res);
      endfunction

      function void take_byte(logic [7:0] b, logic s);
         logic [63:0] area;
         logic [31:0] dim;
         result_type  res;
         if (s) begin
            clear();
            phase = PH_WIDTH;
         end
         case (phase)
            PH_WIDTH, PH_HEIGHT: begin
               if (phase == PH_WIDTH) img_width[8*hdr_count +: 8] = b;
               else img_height[8*hdr_count +: 8] = b;
               hdr_count++;
               if (hdr_count == 4) begin
                  hdr_count = 0;
                  dim = (phase == PH_WIDTH) ? img_width : img_height;
                  if (64'(dim) > DIM_MAX) begin
                     res = '0;
                     res.header_error = 1'b1;
                     expected_runs.push_back(res);
                     phase = PH_ERROR;
                  end else begin
                     phase = (phase == PH_WIDTH) ? PH_HEIGHT : PH_FLAG;
                  end
               end
            end
            PH_FLAG: begin
               alpha_on = (b != 0);
               area = 64'(img_width) * 64'(img_height);
               pix_left = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
               col = '0;
               row = '0;
               phase = (pix_left == 0) ? PH_DONE : PH_LEN;
            end
            PH_LEN: begin
               run_len = b;
               phase = alpha_on ? PH_ALPHA : PH_RED;
            end
            PH_ALPHA: begin
               run_alpha = b;
               // zero alpha: no colour bytes follow
               if (b == 0) place_run(8'd0, 8'd0, 8'd0, 8'd0);
               else phase = PH_RED;
            end
            PH_RED: begin
               run_red = b;
               phase = PH_GREEN;
            end
            PH_GREEN: begin
               run_green = b;
               phase = PH_BLUE;
            end
            PH_BLUE: place_run(run_red, run_green, b, alpha_on ? run_alpha : 8'd255);
            default: ;
         endcase
      endfunction

      function void compare(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_run(result_type got);
         result_type want;
         if (expected_runs.size() == 0) begin
            $error("run descriptor with none due: col %0d row %0d len %0d err %0d",
                   got.start_col, got.start_row, got.run_length, got.header_error);
            errors++;
            return;
         end
         want = expected_runs.pop_front();
         compare("start_col", want.start_col, got.start_col);
         compare("start_row", want.start_row, got.start_row);
         compare("run_length", want.run_length, got.run_length);
         compare("red", want.red, got.red);
         compare("green", want.green, got.green);
         compare("blue", want.blue, got.blue);
         compare("alpha", want.alpha, got.alpha);
         compare("image_done", want.image_done, got.image_done);
         compare("header_error", want.header_error, got.header_error);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_image_start = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_start_col, rsp_start_row;
   logic [7:0]  rsp_run_length, rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic        rsp_image_done, rsp_header_error;

   run_checker  runs = new();
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   bit          hold_rsp = 1'b0;
   int          useful_bytes = 0;
   int          cycles = 0;

   rle_rgba_image_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .req_image_start(req_image_start),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_start_col(rsp_start_col),
      .rsp_start_row(rsp_start_row),
      .rsp_run_length(rsp_run_length),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_alpha(rsp_alpha),
      .rsp_image_done(rsp_image_done),
      .rsp_header_error(rsp_header_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // values read just after the edge are the ones the flops sampled
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset) begin
         if (req_push && !req_full) runs.take_byte(req_data_byte, req_image_start);
         if (rsp_pop && !rsp_empty)
            runs.check_run({rsp_start_col, rsp_start_row, rsp_run_length, rsp_red,
                            rsp_green, rsp_blue, rsp_alpha, rsp_image_done,
                            rsp_header_error});
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = recv_idle ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   task automatic push_byte(logic [7:0] d, logic s);
      int gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= d;
      req_image_start <= s;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_header(logic [31:0] w, logic [31:0] h, logic [7:0] flag);
      push_byte(w[7:0], 1'b1);
      push_byte(w[15:8], 1'b0);
      push_byte(w[23:16], 1'b0);
      push_byte(w[31:24], 1'b0);
      push_byte(h[7:0], 1'b0);
      push_byte(h[15:8], 1'b0);
      push_byte(h[23:16], 1'b0);
      push_byte(h[31:24], 1'b0);
      push_byte(flag, 1'b0);
      useful_bytes += 9;
   endtask

   task automatic send_record(logic [7:0] len, bit with_alpha, logic [7:0] a,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
      push_byte(len, 1'b0);
      useful_bytes++;
      if (with_alpha) begin
         push_byte(a, 1'b0);
         useful_bytes++;
      end
      if (!with_alpha || a != 0) begin
         push_byte(r, 1'b0);
         push_byte(g, 1'b0);
         push_byte(b, 1'b0);
         useful_bytes += 3;
      end
   endtask

   task automatic random_image();
      logic [31:0]     w, h;
      logic [7:0]      flag, len, a;
      longint unsigned left;
      int              kind, records;
      kind = $urandom_range(0, 19);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case (kind)
         0: w = 0;
         1: h = 0;
         2: w = $urandom | 32'h0001_0000;
         3: h = $urandom | 32'h0001_0000;
         4: begin w = 32'hFFFF; h = $urandom_range(1, 3); end
         5: begin w = $urandom_range(1, 3); h = 32'hFFFF; end
         6: begin w = 32'hFFFF; h = 32'hFFFF; end
         default: ;
      endcase
      flag = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'd0;
      send_header(w, h, flag);
      if (64'(w) <= DIM_MAX && 64'(h) <= DIM_MAX) begin
         left = 64'(w) * 64'(h);
         records = $urandom_range(1, 40);
         while (left != 0 && records != 0) begin
            len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 6));
            a = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            send_record(len, flag != 0, a, 8'($urandom), 8'($urandom), 8'($urandom));
            left = left - ((64'(len) > left) ? left : 64'(len));
            records--;
         end
      end
      // trailing bytes: ignored once done or failed, a cut-off record otherwise
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
   endtask

   initial begin
      bit pressed, paused;
      pressed = 1'b0;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stray byte before any image is ignored
      push_byte(8'hFF, 1'b0);
      // 3x2 with alpha: zero-length run, transparent run, clipped last run
      send_header(32'd3, 32'd2, 8'd1);
      send_record(8'd0, 1'b1, 8'd5, 8'd1, 8'd2, 8'd3);
      send_record(8'd4, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      send_record(8'd255, 1'b1, 8'd255, 8'd0, 8'd255, 8'd128);
      push_byte(8'h00, 1'b0);
      // oversized width, then the rest ignored
      send_header(32'hFFFF_FFFF, 32'd2, 8'd3);
      // oversized height
      send_header(32'd1, 32'h0001_0000, 8'd0);
      // empty image
      send_header(32'd0, 32'd5, 8'd0);
      push_byte(8'd7, 1'b0);
      // largest image, no alpha, restarted in the middle of a record
      send_header(32'hFFFF, 32'hFFFF, 8'd0);
      send_record(8'd255, 1'b0, 8'd0, 8'hAA, 8'h55, 8'hFF);
      push_byte(8'd200, 1'b0);
      push_byte(8'd9, 1'b0);

      // trailing bytes of each image come on top of the counted ones
      while (useful_bytes < RANDOM_BYTES - 80) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         random_image();
         if (!pressed && useful_bytes > 300) begin
            // result side held off while single-pixel runs flood in
            pressed = 1'b1;
            hold_rsp = 1'b1;
            send_idle = 1'b0;
            send_header(32'd8, 32'd8, 8'd0);
            repeat (64) send_record(8'd1, 1'b0, 8'd0, 8'($urandom), 8'($urandom),
                                    8'($urandom));
         end
         if (!paused && useful_bytes > 600) begin
            paused = 1'b1;
            req_push <= 1'b0;
            do @(posedge clock); while (runs.pending() != 0);
         end
      end

      req_push <= 1'b0;
      do @(posedge clock); while (runs.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (runs.errors == 0 && runs.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
